>>> rtl/double_ended_queue_top_defines.svh
// Assertion macros for the double-ended queue.
`ifndef DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define DEQ_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deque check failed");

// Next-cycle implication, masked during reset.
`define DEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deque check failed");

`endif

>>> rtl/deq_pkg.sv
// Request codes, status codes and control state for the double-ended queue.
package deq_pkg;

  localparam logic [3:0] REQ_PUSH_TAIL = 4'd0;
  localparam logic [3:0] REQ_PUSH_HEAD = 4'd1;
  localparam logic [3:0] REQ_POP_TAIL  = 4'd2;
  localparam logic [3:0] REQ_POP_HEAD  = 4'd3;
  localparam logic [3:0] REQ_PEEK_TAIL = 4'd4;
  localparam logic [3:0] REQ_PEEK_HEAD = 4'd5;
  localparam logic [3:0] REQ_READ_IDX  = 4'd6;
  localparam logic [3:0] REQ_WRITE_IDX = 4'd7;
  localparam logic [3:0] REQ_CLEAR     = 4'd8;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned POS_W  = 10;
  localparam int unsigned OCC_W  = 11;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

endpackage

>>> rtl/double_ended_queue_top.sv
// Top level of the ring-buffer double-ended queue of 64-bit words.
//
//   channel   direction  handshake              word
//   req       in         req_valid / req_ready  req_type, data_in, position
//   rsp       out        rsp_valid / rsp_ready  data_out, status, occupancy
//
// Push, write, clear and refused requests load the result word directly; a
// request whose result comes from the slot memory (pop, peek, indexed read)
// waits in S_READ for the registered read of the slot memory.
// Reset clears the pointers, count, state and rsp_valid; slot contents start unknown.
// A result held on rsp blocks a new request unless it is taken that cycle.
`include "double_ended_queue_top_defines.svh"

module double_ended_queue_top
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  logic [3:0]          req_type,
  input  logic [WORD_W-1:0]   data_in,
  input  logic [POS_W-1:0]    position,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output logic [WORD_W-1:0]   data_out,
  output logic [1:0]          status,
  output logic [OCC_W-1:0]    occupancy
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned MW = (CW > POS_W) ? CW : POS_W;
  localparam logic [PW:0]   DEPTH_W = (PW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [PW-1:0] LAST_P  = PW'(DEPTH - 1);

  state_t state, state_next;

  logic [PW-1:0] front, front_next;
  logic [CW-1:0] count, count_next;

  logic req_fire;
  logic full, empty, in_range;
  logic [PW-1:0] front_inc, front_dec;
  logic [PW-1:0] offset;
  logic [PW:0]   ring_sum, ring_wrap;
  logic [PW-1:0] ring_addr;

  logic              mem_we, mem_re;
  logic [PW-1:0]     mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_rdata;
  logic [1:0]        status_d;

  assign req_fire = req_valid && req_ready;
  assign full     = (count == DEPTH_C);
  assign empty    = (count == '0);
  assign in_range = (MW'(position) < MW'(count));

  assign front_inc = (front == LAST_P) ? '0 : front + 1'b1;
  assign front_dec = (front == '0) ? LAST_P : front - 1'b1;

  // Pick the offset from the front, then wrap once around the ring.
  always_comb begin
    unique case (req_type)
      REQ_PUSH_TAIL:                     offset = PW'(count);
      REQ_POP_TAIL, REQ_PEEK_TAIL:       offset = PW'(count - 1'b1);
      REQ_READ_IDX, REQ_WRITE_IDX:       offset = PW'(position);
      default:                           offset = '0;
    endcase
  end

  assign ring_sum  = {1'b0, front} + {1'b0, offset};
  assign ring_wrap = (ring_sum >= DEPTH_W) ? ring_sum - DEPTH_W : ring_sum;
  assign ring_addr = ring_wrap[PW-1:0];

  // Request decode: memory access, status and pointer updates.
  always_comb begin
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = ring_addr;
    mem_raddr  = ring_addr;
    status_d   = ST_OK;
    front_next = front;
    count_next = count;
    unique case (req_type)
      REQ_PUSH_TAIL: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          mem_we     = req_fire;
          count_next = count + 1'b1;
        end
      end
      REQ_PUSH_HEAD: begin
        mem_waddr = front_dec;
        if (full) begin
          status_d = ST_FULL;
        end else begin
          mem_we     = req_fire;
          front_next = front_dec;
          count_next = count + 1'b1;
        end
      end
      REQ_POP_TAIL, REQ_PEEK_TAIL: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          mem_re = req_fire;
          if (req_type == REQ_POP_TAIL) begin
            count_next = count - 1'b1;
          end
        end
      end
      REQ_POP_HEAD, REQ_PEEK_HEAD: begin
        mem_raddr = front;
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          mem_re = req_fire;
          if (req_type == REQ_POP_HEAD) begin
            front_next = front_inc;
            count_next = count - 1'b1;
          end
        end
      end
      REQ_READ_IDX, REQ_WRITE_IDX: begin
        priority if (empty) begin
          status_d = ST_EMPTY;
        end else if (!in_range) begin
          status_d = ST_RANGE;
        end else if (req_type == REQ_READ_IDX) begin
          mem_re = req_fire;
        end else begin
          mem_we = req_fire;
        end
      end
      REQ_CLEAR: begin
        front_next = '0;
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  deq_mem #(
    .ENTRIES (DEPTH),
    .DW      (WORD_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (data_in),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (mem_re) begin
          state_next = S_READ;
        end
      end
      S_READ: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the control state.
  always_comb begin
    unique case (state)
      S_IDLE:  req_ready = !rsp_valid || rsp_ready;
      S_READ:  req_ready = 1'b0;
      default: req_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      if (req_fire) begin
        front <= front_next;
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((req_fire && !mem_re) || (state == S_READ)) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Load the result word: immediately, or once the slot read returns.
  always_ff @(posedge clk) begin
    if (req_fire && !mem_re) begin
      data_out  <= '0;
      status    <= status_d;
      occupancy <= OCC_W'(count_next);
    end else if (state == S_READ) begin
      data_out  <= mem_rdata;
      status    <= ST_OK;
      occupancy <= OCC_W'(count);
    end
  end

  `DEQ_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= DEPTH_C)
  `DEQ_ASSERT_NOW(a_read_slot_free, clk, rst, state == S_READ, !rsp_valid && !req_ready)
  `DEQ_ASSERT_NEXT(a_read_enters_wait, clk, rst, req_fire && mem_re, state == S_READ)
  `DEQ_ASSERT_NEXT(a_full_push_holds, clk, rst,
                   req_fire && full && (req_type == REQ_PUSH_TAIL || req_type == REQ_PUSH_HEAD),
                   $stable(count) && $stable(front))

endmodule

>>> rtl/deq_mem.sv
// Single-port-write, registered-read storage for the queue slots.
module deq_mem #(
  parameter int unsigned ENTRIES = 1024,
  parameter int unsigned DW      = 64
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(ENTRIES)-1:0] waddr,
  input  logic [DW-1:0]              wdata,
  input  logic                       re,
  input  logic [$clog2(ENTRIES)-1:0] raddr,
  output logic [DW-1:0]              rdata
);

  logic [DW-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
